### design/jrdm_pkg.sv
// Shared types and constants for the joystick to rotated drive mixer.
// Holds the word formats, register indexes, reset values and step counts.
// Depends on nothing.
package jrdm_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int Q_W        = 16;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 4;

    localparam int AXIS_STEPS = 16;
    localparam int MUL_STEPS  = 16;
    localparam int DIV_STEPS  = 9;

    localparam int Q_ONE     = 16384;
    localparam int LEVEL_MAX = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_X_UPPER_KNEE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOWER_KNEE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_UPPER_KNEE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOWER_KNEE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LOW     = 3'd5;

    localparam logic [SAMPLE_W-1:0] X_UPPER_KNEE_RST = 10'd540;
    localparam logic [SAMPLE_W-1:0] X_LOWER_KNEE_RST = 10'd508;
    localparam logic [SAMPLE_W-1:0] Y_UPPER_KNEE_RST = 10'd530;
    localparam logic [SAMPLE_W-1:0] Y_LOWER_KNEE_RST = 10'd480;
    localparam logic [SAMPLE_W-1:0] FULL_HIGH_RST    = 10'd930;
    localparam logic [SAMPLE_W-1:0] FULL_LOW_RST     = 10'd130;

    typedef struct packed {
        logic [SAMPLE_W-1:0] stick_x;
        logic [SAMPLE_W-1:0] stick_y;
    } stick_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_a_level;
        logic               drive_a_fwd;
        logic               drive_a_rev;
        logic [LEVEL_W-1:0] drive_b_level;
        logic               drive_b_fwd;
        logic               drive_b_rev;
    } drive_word_t;

endpackage

### design/joystick_to_rotated_drive_mixer_core.sv
// Joystick to rotated drive mixer, top level; uses jrdm_pkg and jrdm_axis_map.
// An accepted word passes through 16 divider bits per axis (both axes in parallel),
// 16 shift-add multiply steps and 9 bits of level division before its result is
// loaded. A new word is taken only when idle, after the last result has been loaded.
// Reset restores the register defaults and clears the direction bits.
module joystick_to_rotated_drive_mixer_core
    import jrdm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  stick_word_t            in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output drive_word_t            out_word,
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AXIS  = 3'd1;
    localparam logic [2:0] S_MIX   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [SAMPLE_W-1:0]    x_upper_knee_reg;
    logic [SAMPLE_W-1:0]    x_lower_knee_reg;
    logic [SAMPLE_W-1:0]    y_upper_knee_reg;
    logic [SAMPLE_W-1:0]    y_lower_knee_reg;
    logic [SAMPLE_W-1:0]    full_high_reg;
    logic [SAMPLE_W-1:0]    full_low_reg;

    logic [1:0]             dir_a_reg;
    logic [1:0]             dir_b_reg;
    logic [1:0]             dir_a_next;
    logic [1:0]             dir_b_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    drive_word_t            out_word_reg;

    logic                   start;
    logic                   x_done;
    logic                   y_done;
    logic signed [Q_W-1:0]  x_q;
    logic signed [Q_W-1:0]  y_q;
    logic signed [Q_W-1:0]  x_q_reg;
    logic signed [Q_W-1:0]  y_q_reg;

    logic signed [Q_W:0]    xe;
    logic signed [Q_W:0]    ye;
    logic signed [Q_W:0]    d;
    logic signed [Q_W:0]    s;
    logic [Q_W:0]           ax;
    logic [Q_W:0]           ay;
    logic [Q_W+1:0]         ad_wide;
    logic [Q_W+1:0]         as_wide;
    logic [Q_W:0]           ad;
    logic [Q_W:0]           as_mag;
    logic [Q_W:0]           m;

    logic [Q_W:0]           mag_a_reg;
    logic [Q_W:0]           mag_b_reg;
    logic [Q_W-1:0]         r_sh_reg;
    logic [Q_W:0]           m_reg;
    logic                   m_zero_reg;
    logic                   d_pos_reg;
    logic                   d_neg_reg;
    logic                   s_pos_reg;
    logic                   s_neg_reg;

    logic [2*Q_W+1:0]       acc_a_reg;
    logic [2*Q_W+1:0]       acc_b_reg;
    logic [Q_W+1:0]         sum_a;
    logic [Q_W+1:0]         sum_b;

    logic [2*Q_W+LEVEL_W:0] p255_a;
    logic [2*Q_W+LEVEL_W:0] p255_b;
    logic [26:0]            n_a_reg;
    logic [26:0]            n_b_reg;
    logic [24:0]            dsh_reg;
    logic [8:0]             quo_a_reg;
    logic [8:0]             quo_b_reg;
    logic                   ge_a;
    logic                   ge_b;
    logic [LEVEL_W-1:0]     level_a;
    logic [LEVEL_W-1:0]     level_b;
    logic                   load_out;

    assign start = in_valid && in_ready;

    jrdm_axis_map u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sample    (in_word.stick_x),
        .upper     (x_upper_knee_reg),
        .lower     (x_lower_knee_reg),
        .full_high (full_high_reg),
        .full_low  (full_low_reg),
        .done      (x_done),
        .q         (x_q)
    );

    jrdm_axis_map u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sample    (in_word.stick_y),
        .upper     (y_upper_knee_reg),
        .lower     (y_lower_knee_reg),
        .full_high (full_high_reg),
        .full_low  (full_low_reg),
        .done      (y_done),
        .q         (y_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_upper_knee_reg <= X_UPPER_KNEE_RST;
            x_lower_knee_reg <= X_LOWER_KNEE_RST;
            y_upper_knee_reg <= Y_UPPER_KNEE_RST;
            y_lower_knee_reg <= Y_LOWER_KNEE_RST;
            full_high_reg    <= FULL_HIGH_RST;
            full_low_reg     <= FULL_LOW_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_X_UPPER_KNEE: x_upper_knee_reg <= cfg_data;
                CFG_X_LOWER_KNEE: x_lower_knee_reg <= cfg_data;
                CFG_Y_UPPER_KNEE: y_upper_knee_reg <= cfg_data;
                CFG_Y_LOWER_KNEE: y_lower_knee_reg <= cfg_data;
                CFG_FULL_HIGH:    full_high_reg    <= cfg_data;
                CFG_FULL_LOW:     full_low_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        xe      = {x_q_reg[Q_W-1], x_q_reg};
        ye      = {y_q_reg[Q_W-1], y_q_reg};
        ax      = xe[Q_W] ? 17'(-xe) : 17'(xe);
        ay      = ye[Q_W] ? 17'(-ye) : 17'(ye);
        d       = xe - ye;
        s       = xe + ye;
        ad_wide = d[Q_W] ? 18'(-$signed({d[Q_W], d})) : 18'({d[Q_W], d});
        as_wide = s[Q_W] ? 18'(-$signed({s[Q_W], s})) : 18'({s[Q_W], s});
        ad      = ad_wide[Q_W:0];
        as_mag  = as_wide[Q_W:0];
        m       = (ad > as_mag) ? ad : as_mag;
    end

    always_comb
    begin
        sum_a  = acc_a_reg[2*Q_W+1:Q_W] + (r_sh_reg[0] ? {1'b0, mag_a_reg} : '0);
        sum_b  = acc_b_reg[2*Q_W+1:Q_W] + (r_sh_reg[0] ? {1'b0, mag_b_reg} : '0);
        p255_a = {acc_a_reg[2*Q_W:0], 8'b0} - {8'b0, acc_a_reg[2*Q_W:0]};
        p255_b = {acc_b_reg[2*Q_W:0], 8'b0} - {8'b0, acc_b_reg[2*Q_W:0]};
        ge_a   = n_a_reg >= {2'b00, dsh_reg};
        ge_b   = n_b_reg >= {2'b00, dsh_reg};
        if (m_zero_reg)
        begin
            level_a = '0;
            level_b = '0;
        end
        else
        begin
            level_a = (quo_a_reg > 9'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : quo_a_reg[LEVEL_W-1:0];
            level_b = (quo_b_reg > 9'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : quo_b_reg[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (x_done && y_done)
                begin
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                state_next = S_MUL;
                count_next = '0;
            end
            S_MUL:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_DIV;
                count_next = '0;
            end
            S_DIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dir_a_next = dir_a_reg;
        dir_b_next = dir_b_reg;
        if (load_out)
        begin
            if (d_pos_reg)
            begin
                dir_a_next = 2'b01;
            end
            else if (d_neg_reg)
            begin
                dir_a_next = 2'b10;
            end
            if (s_pos_reg)
            begin
                dir_b_next = 2'b01;
            end
            else if (s_neg_reg)
            begin
                dir_b_next = 2'b10;
            end
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dir_a_reg     <= 2'b00;
            dir_b_reg     <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dir_a_reg     <= dir_a_next;
            dir_b_reg     <= dir_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_AXIS:
            begin
                x_q_reg <= x_q;
                y_q_reg <= y_q;
            end
            S_MIX:
            begin
                mag_a_reg  <= ad;
                mag_b_reg  <= as_mag;
                r_sh_reg   <= (ax > ay) ? ax[Q_W-1:0] : ay[Q_W-1:0];
                m_reg      <= m;
                m_zero_reg <= (m == '0);
                d_pos_reg  <= (d > 17'sd0);
                d_neg_reg  <= d[Q_W];
                s_pos_reg  <= (s > 17'sd0);
                s_neg_reg  <= s[Q_W];
                acc_a_reg  <= '0;
                acc_b_reg  <= '0;
            end
            S_MUL:
            begin
                acc_a_reg <= {1'b0, sum_a, acc_a_reg[Q_W-1:1]};
                acc_b_reg <= {1'b0, sum_b, acc_b_reg[Q_W-1:1]};
                r_sh_reg  <= {1'b0, r_sh_reg[Q_W-1:1]};
            end
            S_SCALE:
            begin
                n_a_reg   <= p255_a[2*Q_W+LEVEL_W:14];
                n_b_reg   <= p255_b[2*Q_W+LEVEL_W:14];
                dsh_reg   <= {m_reg, 8'b0};
                quo_a_reg <= '0;
                quo_b_reg <= '0;
            end
            S_DIV:
            begin
                n_a_reg   <= ge_a ? 27'(n_a_reg - {2'b00, dsh_reg}) : n_a_reg;
                n_b_reg   <= ge_b ? 27'(n_b_reg - {2'b00, dsh_reg}) : n_b_reg;
                quo_a_reg <= {quo_a_reg[7:0], ge_a};
                quo_b_reg <= {quo_b_reg[7:0], ge_b};
                dsh_reg   <= {1'b0, dsh_reg[24:1]};
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_word_reg.drive_a_level <= level_a;
            out_word_reg.drive_a_fwd   <= dir_a_next[0];
            out_word_reg.drive_a_rev   <= dir_a_next[1];
            out_word_reg.drive_b_level <= level_b;
            out_word_reg.drive_b_fwd   <= dir_b_next[0];
            out_word_reg.drive_b_rev   <= dir_b_next[1];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### design/jrdm_axis_map.sv
// Maps one raw stick sample to a signed Q2.14 deflection with a dead band.
// The quotient is formed by a bit-serial restoring divider, one bit per cycle.
// Depends on jrdm_pkg.
module jrdm_axis_map
    import jrdm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic [SAMPLE_W-1:0]        upper,
    input  logic [SAMPLE_W-1:0]        lower,
    input  logic [SAMPLE_W-1:0]        full_high,
    input  logic [SAMPLE_W-1:0]        full_low,
    output logic                       done,
    output logic signed [Q_W-1:0]      q
);

    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_LOWER = 2'd2;

    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic                    done_next;
    logic [1:0]              mode_reg;
    logic                    neg_reg;
    logic                    ovf_reg;
    logic [SAMPLE_W-1:0]     den_reg;
    logic [SAMPLE_W-1:0]     rem_reg;
    logic [SAMPLE_W-1:0]     rem_next;
    logic [Q_W-1:0]          bits_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [Q_W-1:0]          quo_next;

    logic                    above;
    logic                    below;
    logic signed [SAMPLE_W:0] num_up;
    logic signed [SAMPLE_W:0] den_up;
    logic signed [SAMPLE_W:0] num_lo;
    logic signed [SAMPLE_W:0] den_lo;
    logic signed [SAMPLE_W:0] sel_num;
    logic signed [SAMPLE_W:0] sel_den;
    logic [SAMPLE_W:0]       num_abs;
    logic [SAMPLE_W:0]       den_abs;
    logic [SAMPLE_W-1:0]     num_mag;
    logic [SAMPLE_W-1:0]     den_mag;
    logic [1:0]              start_mode;
    logic                    start_ovf;
    logic [SAMPLE_W:0]       trial;
    logic                    trial_ge;
    logic [Q_W-1:0]          quo_sat;
    logic signed [Q_W+1:0]   q_wide;
    logic signed [Q_W+1:0]   q_shift;

    always_comb
    begin
        above   = sample > upper;
        below   = sample < lower;
        num_up  = $signed({1'b0, sample}) - $signed({1'b0, upper});
        den_up  = $signed({1'b0, full_high}) - $signed({1'b0, upper});
        num_lo  = $signed({1'b0, sample}) - $signed({1'b0, full_low});
        den_lo  = $signed({1'b0, lower}) - $signed({1'b0, full_low});
        sel_num = above ? num_up : num_lo;
        sel_den = above ? den_up : den_lo;
        num_abs = sel_num[SAMPLE_W] ? 11'(-sel_num) : 11'(sel_num);
        den_abs = sel_den[SAMPLE_W] ? 11'(-sel_den) : 11'(sel_den);
        num_mag = num_abs[SAMPLE_W-1:0];
        den_mag = den_abs[SAMPLE_W-1:0];
        if (above)
        begin
            start_mode = (den_mag != '0) ? MODE_UPPER : MODE_ZERO;
        end
        else if (below)
        begin
            start_mode = (den_mag != '0) ? MODE_LOWER : MODE_ZERO;
        end
        else
        begin
            start_mode = MODE_ZERO;
        end
        start_ovf = {2'b00, num_mag[SAMPLE_W-1:2]} >= den_mag;
    end

    always_comb
    begin
        trial    = {rem_reg, bits_reg[Q_W-1]};
        trial_ge = trial >= {1'b0, den_reg};
        rem_next = trial_ge ? SAMPLE_W'(trial - {1'b0, den_reg}) : trial[SAMPLE_W-1:0];
        quo_next = {quo_reg[Q_W-2:0], trial_ge};
        busy_next  = busy_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
        end
        else if (busy_reg)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(AXIS_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= start_mode;
            neg_reg  <= sel_num[SAMPLE_W] ^ sel_den[SAMPLE_W];
            ovf_reg  <= start_ovf;
            den_reg  <= den_mag;
            rem_reg  <= start_ovf ? '0 : {2'b00, num_mag[SAMPLE_W-1:2]};
            bits_reg <= {num_mag[1:0], 14'b0};
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[Q_W-2:0], 1'b0};
            quo_reg  <= quo_next;
        end
    end

    always_comb
    begin
        quo_sat = ovf_reg ? '1 : quo_reg;
        q_wide  = neg_reg ? -$signed({2'b00, quo_sat}) : $signed({2'b00, quo_sat});
        q_shift = (mode_reg == MODE_LOWER) ? q_wide - 18'sd16384 : q_wide;
        case (mode_reg)
            MODE_UPPER, MODE_LOWER:
            begin
                if (q_shift > 18'sd32767)
                begin
                    q = 16'sh7FFF;
                end
                else if (q_shift < -18'sd32768)
                begin
                    q = 16'sh8000;
                end
                else
                begin
                    q = q_shift[Q_W-1:0];
                end
            end
            default:
            begin
                q = '0;
            end
        endcase
    end

    assign done = done_reg;

endmodule

### tb/jrdm_drive_checker.sv
`timescale 1ns / 100ps
// Drive word checker for the joystick to rotated drive mixer core.
// Predicts each drive word from accepted stick words and register writes; compares in order.
// Depends on jrdm_pkg.
module jrdm_drive_checker
    import jrdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  stick_word_t           in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  drive_word_t           out_word,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expect_count
);

    localparam logic [1:0] DIR_FWD = 2'b01;
    localparam logic [1:0] DIR_REV = 2'b10;
    localparam int REPORT_LIMIT = 10;
    localparam longint Q_MAX = 32767;
    localparam longint Q_MIN = -32768;

    typedef struct {
        stick_word_t stick;
        drive_word_t drive;
    } drive_expect_t;

    drive_expect_t drive_expected_q[$];

    logic [SAMPLE_W-1:0] x_upper;
    logic [SAMPLE_W-1:0] x_lower;
    logic [SAMPLE_W-1:0] y_upper;
    logic [SAMPLE_W-1:0] y_lower;
    logic [SAMPLE_W-1:0] full_hi;
    logic [SAMPLE_W-1:0] full_lo;
    logic [1:0]          dir_a;
    logic [1:0]          dir_b;

    function automatic longint map_axis(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] upper,
                                        logic [SAMPLE_W-1:0] lower);
        longint sv;
        longint su;
        longint sl;
        longint fh;
        longint fl;
        longint den;
        longint q;
        sv = longint'(v);
        su = longint'(upper);
        sl = longint'(lower);
        fh = longint'(full_hi);
        fl = longint'(full_lo);
        q = 0;
        if (v > upper)
        begin
            den = fh - su;
            if (den != 0)
                q = ((sv - su) * Q_ONE) / den;
        end
        else if (v < lower)
        begin
            den = sl - fl;
            if (den != 0)
                q = ((sv - fl) * Q_ONE) / den - Q_ONE;
        end
        if (q > Q_MAX)
            q = Q_MAX;
        if (q < Q_MIN)
            q = Q_MIN;
        return q;
    endfunction

    function automatic logic [LEVEL_W-1:0] drive_level(longint mag, longint r, longint m);
        longint lv;
        lv = (mag * r * LEVEL_MAX) / (m * Q_ONE);
        if (lv > LEVEL_MAX)
            lv = LEVEL_MAX;
        return lv[LEVEL_W-1:0];
    endfunction

    function automatic logic [1:0] next_dir(logic [1:0] held, longint v);
        if (v > 0)
            return DIR_FWD;
        if (v < 0)
            return DIR_REV;
        return held;
    endfunction

    function automatic drive_word_t mix_drive(stick_word_t w);
        longint x;
        longint y;
        longint ax;
        longint ay;
        longint r;
        longint d;
        longint s;
        longint diff_mag;
        longint sum_mag;
        longint m;
        drive_word_t o;
        x = map_axis(w.stick_x, x_upper, x_lower);
        y = map_axis(w.stick_y, y_upper, y_lower);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r = (ax > ay) ? ax : ay;
        d = x - y;
        s = x + y;
        diff_mag = (d < 0) ? -d : d;
        sum_mag = (s < 0) ? -s : s;
        m = (diff_mag > sum_mag) ? diff_mag : sum_mag;
        o = '0;
        if (m != 0)
        begin
            o.drive_a_level = drive_level(diff_mag, r, m);
            o.drive_b_level = drive_level(sum_mag, r, m);
        end
        dir_a = next_dir(dir_a, d);
        dir_b = next_dir(dir_b, s);
        o.drive_a_fwd = dir_a[0];
        o.drive_a_rev = dir_a[1];
        o.drive_b_fwd = dir_b[0];
        o.drive_b_rev = dir_b[1];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_expect_t head;
        logic bad;
        if (!rst_n)
        begin
            x_upper = X_UPPER_KNEE_RST;
            x_lower = X_LOWER_KNEE_RST;
            y_upper = Y_UPPER_KNEE_RST;
            y_lower = Y_LOWER_KNEE_RST;
            full_hi = FULL_HIGH_RST;
            full_lo = FULL_LOW_RST;
            dir_a = '0;
            dir_b = '0;
            fail_count = 0;
            drive_expected_q.delete();
            expect_count <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_X_UPPER_KNEE: x_upper = cfg_data;
                    CFG_X_LOWER_KNEE: x_lower = cfg_data;
                    CFG_Y_UPPER_KNEE: y_upper = cfg_data;
                    CFG_Y_LOWER_KNEE: y_lower = cfg_data;
                    CFG_FULL_HIGH:    full_hi = cfg_data;
                    CFG_FULL_LOW:     full_lo = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (drive_expected_q.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display({"%0t: drive word with nothing outstanding: ",
                                  "a=%0d f=%0b r=%0b b=%0d f=%0b r=%0b"},
                                 $realtime, out_word.drive_a_level, out_word.drive_a_fwd,
                                 out_word.drive_a_rev, out_word.drive_b_level,
                                 out_word.drive_b_fwd, out_word.drive_b_rev);
                    fail_count++;
                end
                else
                begin
                    head = drive_expected_q.pop_front();
                    bad = (out_word.drive_a_level !== head.drive.drive_a_level)
                       || (out_word.drive_a_fwd !== head.drive.drive_a_fwd)
                       || (out_word.drive_a_rev !== head.drive.drive_a_rev)
                       || (out_word.drive_b_level !== head.drive.drive_b_level)
                       || (out_word.drive_b_fwd !== head.drive.drive_b_fwd)
                       || (out_word.drive_b_rev !== head.drive.drive_b_rev);
                    if (bad)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"%0t: stick x=%0d y=%0d expected a=%0d f=%0b r=%0b ",
                                      "b=%0d f=%0b r=%0b, got a=%0d f=%0b r=%0b b=%0d f=%0b r=%0b"},
                                     $realtime, head.stick.stick_x, head.stick.stick_y,
                                     head.drive.drive_a_level, head.drive.drive_a_fwd,
                                     head.drive.drive_a_rev, head.drive.drive_b_level,
                                     head.drive.drive_b_fwd, head.drive.drive_b_rev,
                                     out_word.drive_a_level, out_word.drive_a_fwd,
                                     out_word.drive_a_rev, out_word.drive_b_level,
                                     out_word.drive_b_fwd, out_word.drive_b_rev);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                head.stick = in_word;
                head.drive = mix_drive(in_word);
                drive_expected_q.push_back(head);
            end
            expect_count <= drive_expected_q.size();
        end
    end

endmodule

### tb/tb_joystick_to_rotated_drive_mixer_core.sv
`timescale 1ns / 100ps
// Testbench top for the joystick to rotated drive mixer core: clock, reset, stick words,
// register writes and receiver stalls; the verdict comes from jrdm_drive_checker.
// Depends on jrdm_pkg, jrdm_drive_checker and joystick_to_rotated_drive_mixer_core.
module tb_joystick_to_rotated_drive_mixer_core;
    import jrdm_pkg::*;

    localparam int CFG_REGS     = 6;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    stick_word_t           in_word;
    logic                  out_valid;
    logic                  out_ready;
    drive_word_t           out_word;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    expect_count;

    logic [SAMPLE_W-1:0] cfg_val [CFG_REGS];
    int                  idle_pct;
    int                  stall_pct;
    bit                  hold_req;
    int                  quiet_cycles = 0;

    joystick_to_rotated_drive_mixer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    jrdm_drive_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .expect_count (expect_count)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer(stick_word_t w);
        int gap;
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_xy(int x, int y);
        stick_word_t w;
        w.stick_x = x[SAMPLE_W-1:0];
        w.stick_y = y[SAMPLE_W-1:0];
        offer(w);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expect_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(bit with_spare);
        for (int i = 0; i < CFG_REGS; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= cfg_val[i];
            @(posedge clk);
        end
        if (with_spare)
        begin
            cfg_index <= CFG_SPARE_A;
            cfg_data <= CFG_DATA_W'($urandom_range(1023));
            @(posedge clk);
            cfg_index <= CFG_SPARE_B;
            cfg_data <= CFG_DATA_W'($urandom_range(1023));
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] upper,
                                                        logic [SAMPLE_W-1:0] lower);
        int v;
        int jitter;
        jitter = $urandom_range(16);
        case ($urandom_range(6))
            0, 1:    v = $urandom_range(1023);
            2:       v = int'(upper) + jitter - 8;
            3:       v = int'(lower) + jitter - 8;
            4:       v = int'(cfg_val[CFG_FULL_HIGH]) + jitter - 8;
            5:       v = int'(cfg_val[CFG_FULL_LOW]) + jitter - 8;
            default: v = $urandom_range(1) ? 1023 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        stick_word_t w;
        int fl;
        int lo;
        int up;
        int fh;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        cfg_val[CFG_X_UPPER_KNEE] = X_UPPER_KNEE_RST;
        cfg_val[CFG_X_LOWER_KNEE] = X_LOWER_KNEE_RST;
        cfg_val[CFG_Y_UPPER_KNEE] = Y_UPPER_KNEE_RST;
        cfg_val[CFG_Y_LOWER_KNEE] = Y_LOWER_KNEE_RST;
        cfg_val[CFG_FULL_HIGH]    = FULL_HIGH_RST;
        cfg_val[CFG_FULL_LOW]     = FULL_LOW_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default knees: corners, dead band, knee edges, full points and zero drive cases.
        offer_xy(0, 0);
        offer_xy(1023, 1023);
        offer_xy(0, 1023);
        offer_xy(1023, 0);
        offer_xy(520, 500);
        offer_xy(540, 530);
        offer_xy(541, 530);
        offer_xy(507, 479);
        offer_xy(930, 530);
        offer_xy(130, 500);
        offer_xy(930, 930);
        offer_xy(930, 130);
        offer_xy(130, 930);
        offer_xy(130, 130);
        offer_xy(735, 505);
        offer_xy(1023, 512);
        drain_results();

        // Crossed x knees, saturation both ways on x, zero spans on y.
        cfg_val[CFG_X_UPPER_KNEE] = 10'd300;
        cfg_val[CFG_X_LOWER_KNEE] = 10'd700;
        cfg_val[CFG_Y_UPPER_KNEE] = 10'd541;
        cfg_val[CFG_Y_LOWER_KNEE] = 10'd599;
        cfg_val[CFG_FULL_HIGH]    = 10'd541;
        cfg_val[CFG_FULL_LOW]     = 10'd599;
        apply_config(1'b1);
        offer_xy(1023, 1023);
        offer_xy(0, 0);
        offer_xy(500, 600);
        offer_xy(300, 598);
        offer_xy(299, 541);
        offer_xy(650, 100);
        drain_results();

        // Full points inside the knees, so both spans are negative.
        cfg_val[CFG_X_UPPER_KNEE] = 10'd800;
        cfg_val[CFG_X_LOWER_KNEE] = 10'd200;
        cfg_val[CFG_Y_UPPER_KNEE] = 10'd800;
        cfg_val[CFG_Y_LOWER_KNEE] = 10'd200;
        cfg_val[CFG_FULL_HIGH]    = 10'd500;
        cfg_val[CFG_FULL_LOW]     = 10'd600;
        apply_config(1'b0);
        offer_xy(1023, 0);
        offer_xy(0, 1023);
        offer_xy(900, 100);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cfg_val[CFG_X_UPPER_KNEE] = X_UPPER_KNEE_RST;
                    cfg_val[CFG_X_LOWER_KNEE] = X_LOWER_KNEE_RST;
                    cfg_val[CFG_Y_UPPER_KNEE] = Y_UPPER_KNEE_RST;
                    cfg_val[CFG_Y_LOWER_KNEE] = Y_LOWER_KNEE_RST;
                    cfg_val[CFG_FULL_HIGH]    = FULL_HIGH_RST;
                    cfg_val[CFG_FULL_LOW]     = FULL_LOW_RST;
                end
                2:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        cfg_val[i] = '0;
                end
                3:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        cfg_val[i] = '1;
                end
                4:
                begin
                    fl = $urandom_range(300);
                    fh = $urandom_range(1023, 700);
                    lo = $urandom_range(500, fl);
                    up = $urandom_range(700, lo);
                    cfg_val[CFG_X_LOWER_KNEE] = lo[SAMPLE_W-1:0];
                    cfg_val[CFG_X_UPPER_KNEE] = up[SAMPLE_W-1:0];
                    lo = $urandom_range(500, fl);
                    up = $urandom_range(700, lo);
                    cfg_val[CFG_Y_LOWER_KNEE] = lo[SAMPLE_W-1:0];
                    cfg_val[CFG_Y_UPPER_KNEE] = up[SAMPLE_W-1:0];
                    cfg_val[CFG_FULL_HIGH]    = fh[SAMPLE_W-1:0];
                    cfg_val[CFG_FULL_LOW]     = fl[SAMPLE_W-1:0];
                end
                5:
                begin
                    cfg_val[CFG_X_UPPER_KNEE] = SAMPLE_W'($urandom_range(400));
                    cfg_val[CFG_X_LOWER_KNEE] = SAMPLE_W'($urandom_range(1023, 600));
                    cfg_val[CFG_Y_UPPER_KNEE] = SAMPLE_W'($urandom_range(400));
                    cfg_val[CFG_Y_LOWER_KNEE] = SAMPLE_W'($urandom_range(1023, 600));
                    cfg_val[CFG_FULL_HIGH]    = SAMPLE_W'($urandom_range(300));
                    cfg_val[CFG_FULL_LOW]     = SAMPLE_W'($urandom_range(1023, 700));
                end
                6:
                begin
                    cfg_val[CFG_X_UPPER_KNEE] = 10'd512;
                    cfg_val[CFG_X_LOWER_KNEE] = 10'd511;
                    cfg_val[CFG_Y_UPPER_KNEE] = '1;
                    cfg_val[CFG_Y_LOWER_KNEE] = '0;
                    cfg_val[CFG_FULL_HIGH]    = '1;
                    cfg_val[CFG_FULL_LOW]     = '0;
                end
                default:
                begin
                    for (int i = 0; i < CFG_REGS; i++)
                        cfg_val[i] = SAMPLE_W'($urandom_range(1023));
                end
            endcase
            apply_config(p == 1 || p == 5);

            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
            endcase

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 4 && k == 20)
                    hold_req = 1'b1;
                if (p == 6 && k == 50)
                    drain_results();
                w.stick_x = pick_sample(cfg_val[CFG_X_UPPER_KNEE], cfg_val[CFG_X_LOWER_KNEE]);
                w.stick_y = pick_sample(cfg_val[CFG_Y_UPPER_KNEE], cfg_val[CFG_Y_LOWER_KNEE]);
                offer(w);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expect_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
